@@ src/bhkv_pkg.sv @@
// Package for the bucketed hash key-value table.
// Holds mode and status codes, the controller state type and the command/status structs.
package bhkv_pkg;

   localparam logic [2:0] MODE_FIND  = 3'd0;
   localparam logic [2:0] MODE_ADD   = 3'd1;
   localparam logic [2:0] MODE_DEL   = 3'd2;
   localparam logic [2:0] MODE_POP   = 3'd3;
   localparam logic [2:0] MODE_START = 3'd4;
   localparam logic [2:0] MODE_NEXT  = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_EXISTS    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   // Controller states, one-hot.
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_FILL  = 9'b000000010,
      S_SCAN  = 9'b000000100,
      S_CHECK = 9'b000001000,
      S_SHIFT = 9'b000010000,
      S_WRITE = 9'b000100000,
      S_BKT   = 9'b001000000,
      S_GRAB  = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture request, set bucket from key (0 for pop)
      logic fill_rd;     // read fill of current bucket (registered)
      logic slot_rd;     // read slot at index (registered)
      logic idx_clear;   // index <= 0
      logic idx_inc;     // index <= index + 1
      logic idx_head;    // index <= fill - 1 (pop) or fill - 1 - cursor slot
      logic hit_save;    // remember index as match
      logic shift_wr;    // write slot[index-1] <= read data
      logic add_wr;      // write new pair at fill
      logic fill_dec;    // fill <= fill - 1
      logic fill_inc;    // fill <= fill + 1
      logic bkt_inc;     // scan bucket + 1
      logic cur_bump;    // cursor slot + 1
      logic cur_next;    // cursor bucket + 1, slot 0
      logic cur_clear;   // iteration start
      logic out_data;    // result takes read data
      logic out_val;     // result value only
      logic use_cursor;  // bucket comes from cursor
      logic [2:0] status;
      logic rsp_set;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] mode;
      logic key_match;   // read slot key equals request key
      logic idx_end;     // index + 1 >= fill, or index at last way
      logic fill_zero;
      logic fill_full;
      logic cur_in;      // index < fill (delete), cursor slot < fill (next), else 1
      logic bkt_last;    // bucket is the last one
      logic cur_end;     // cursor bucket past end
      logic hit;
      logic rsp_busy;
   } stat_type;

endpackage

@@ src/bhkv_if.sv @@
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload width set by parameter.
interface bhkv_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/bhkv_ctrl.sv @@
// Controller state machine of the key-value table.
// Depends on bhkv_pkg; drives the datapath through cmd_type.
module bhkv_ctrl
   import bhkv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !st.rsp_busy;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            // Fill of the current bucket is now readable.
            cmd.fill_rd = 1'b1;
            cmd.use_cursor = (st.mode == MODE_NEXT);
            priority case (st.mode)
               MODE_FIND, MODE_ADD, MODE_DEL: state_in = S_SCAN;
               MODE_POP:  state_in = S_BKT;
               MODE_NEXT: begin
                  if (st.cur_end) begin
                     cmd.status = ST_DONE; cmd.rsp_set = 1'b1; state_in = S_IDLE;
                  end else state_in = S_BKT;
               end
               MODE_START: begin
                  cmd.cur_clear = 1'b1; cmd.status = ST_OK;
                  cmd.rsp_set = 1'b1; state_in = S_IDLE;
               end
               default: begin
                  cmd.status = ST_OK; cmd.rsp_set = 1'b1; state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // Issue a read for slot index, or finish the bucket.
            if (st.fill_zero || st.hit) state_in = S_WRITE;
            else begin
               cmd.slot_rd = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.key_match) begin
               cmd.hit_save = 1'b1;
               if (st.mode == MODE_FIND) begin
                  cmd.out_val = 1'b1; cmd.status = ST_OK;
                  cmd.rsp_set = 1'b1; state_in = S_IDLE;
               end else if (st.mode == MODE_DEL) begin
                  cmd.idx_inc = 1'b1; state_in = S_SHIFT;
               end else state_in = S_WRITE;
            end else if (st.idx_end) state_in = S_WRITE;
            else begin
               cmd.idx_inc = 1'b1; state_in = S_SCAN;
            end
         end
         S_SHIFT: begin
            // Delete: move slots above the hit down one, then drop fill; pop and next read a slot.
            if (st.cur_in) begin
               cmd.slot_rd = 1'b1; state_in = S_GRAB;
            end else begin
               cmd.fill_dec = 1'b1; cmd.status = ST_OK;
               cmd.rsp_set = 1'b1; state_in = S_IDLE;
            end
         end
         S_GRAB: begin
            if (st.mode == MODE_DEL) begin
               cmd.shift_wr = 1'b1; cmd.idx_inc = 1'b1; state_in = S_SHIFT;
            end else begin
               cmd.out_data = 1'b1; cmd.status = ST_OK; cmd.rsp_set = 1'b1;
               if (st.mode == MODE_POP) cmd.fill_dec = 1'b1;
               else cmd.cur_bump = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WRITE: begin
            // Scan ended without a match (or add found a duplicate).
            if (st.mode == MODE_ADD) begin
               if (st.hit) cmd.status = ST_EXISTS;
               else if (st.fill_full) cmd.status = ST_FULL;
               else begin
                  cmd.add_wr = 1'b1; cmd.fill_inc = 1'b1; cmd.status = ST_OK;
               end
            end else cmd.status = ST_NOT_FOUND;
            cmd.rsp_set = 1'b1;
            state_in = S_IDLE;
         end
         S_BKT: begin
            // Pop and next: walk buckets until one has an entry to return.
            cmd.use_cursor = (st.mode == MODE_NEXT);
            if ((st.mode == MODE_POP) ? !st.fill_zero : st.cur_in) begin
               cmd.idx_head = 1'b1;
               cmd.slot_rd = 1'b0;
               state_in = S_SHIFT;
            end else if (st.bkt_last) begin
               if (st.mode == MODE_NEXT) cmd.cur_next = 1'b1;
               cmd.status = (st.mode == MODE_POP) ? ST_EMPTY : ST_DONE;
               cmd.rsp_set = 1'b1;
               state_in = S_IDLE;
            end else begin
               if (st.mode == MODE_NEXT) cmd.cur_next = 1'b1;
               else cmd.bkt_inc = 1'b1;
               state_in = S_FILL;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("controller state not one-hot");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_FILL))
      else $error("accepted request did not start");
   a_no_dual_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.shift_wr && cmd.add_wr))
      else $error("two slot writes at once");
`endif

endmodule

@@ src/bhkv_dp.sv @@
// Datapath of the key-value table: slot memories, fill table, cursor, result register.
// Depends on bhkv_pkg; commanded by bhkv_ctrl.
module bhkv_dp
   import bhkv_pkg::*;
#(
   parameter int BUCKETS = 256,
   parameter int WAYS = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [2:0]     req_mode,
   input  logic [63:0]    req_key,
   input  logic [63:0]    req_value,
   input  cmd_type        cmd,
   output stat_type       st,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [2:0]     rsp_status,
   output logic [63:0]    rsp_out_key,
   output logic [63:0]    rsp_out_value
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FW = $clog2(WAYS + 1);
   localparam int CW = $clog2(BUCKETS + 1);
   localparam int AW = BW + SW;

   logic [63:0] slot_key_mem [BUCKETS*WAYS];
   logic [63:0] slot_val_mem [BUCKETS*WAYS];
   logic [FW-1:0] fill_mem [BUCKETS];
   logic [BUCKETS-1:0] fill_ok_ff;

   logic [2:0]   mode_ff;
   logic [63:0]  key_ff, val_ff;
   logic [BW-1:0] bkt_ff;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] idx_ff;
   logic          hit_ff;
   logic [63:0]  rkey_ff, rval_ff;
   logic [CW-1:0] cb_ff;
   logic [FW-1:0] cs_ff;
   logic          rv_ff;
   logic [2:0]    rs_ff;
   logic [63:0]   rk_ff, ro_ff;

   logic [BW-1:0] bsel;
   logic [AW-1:0] addr;
   logic [BW-1:0] key_bkt;

   // Bucket index is the key mod BUCKETS.
   assign key_bkt = BW'(req_key % 64'(BUCKETS));
   assign bsel = cmd.use_cursor ? cb_ff[BW-1:0] : bkt_ff;
   assign addr = AW'(32'(bkt_ff) * WAYS + 32'(idx_ff));

   // Request capture, bucket and index registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode; key_ff <= req_key; val_ff <= req_value;
         bkt_ff <= (req_mode == MODE_POP) ? '0 : key_bkt;
         hit_ff <= 1'b0;
      end
      if (cmd.fill_rd) fill_ff <= fill_ok_ff[bsel] ? fill_mem[bsel] : '0;
      if (cmd.fill_rd && cmd.use_cursor) bkt_ff <= cb_ff[BW-1:0];
      if (cmd.bkt_inc) bkt_ff <= bkt_ff + 1'b1;
      if (cmd.hit_save) hit_ff <= 1'b1;
      if (cmd.idx_clear) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
      else if (cmd.idx_head)
         idx_ff <= (mode_ff == MODE_POP) ? fill_ff - 1'b1 : fill_ff - 1'b1 - cs_ff;
      if (cmd.slot_rd) begin
         rkey_ff <= slot_key_mem[addr];
         rval_ff <= slot_val_mem[addr];
      end
   end

   // Slot memory writes: delete shift or add at fill.
   always_ff @(posedge clock) begin
      if (cmd.shift_wr) begin
         slot_key_mem[AW'(addr - 1'b1)] <= rkey_ff;
         slot_val_mem[AW'(addr - 1'b1)] <= rval_ff;
      end else if (cmd.add_wr) begin
         slot_key_mem[AW'(32'(bkt_ff) * WAYS + 32'(fill_ff))] <= key_ff;
         slot_val_mem[AW'(32'(bkt_ff) * WAYS + 32'(fill_ff))] <= val_ff;
      end
   end

   // Fill table with per-bucket valid bits cleared by reset.
   always_ff @(posedge clock) begin
      if (cmd.fill_dec) fill_mem[bkt_ff] <= fill_ff - 1'b1;
      else if (cmd.fill_inc) fill_mem[bkt_ff] <= fill_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) fill_ok_ff <= '0;
      else if (cmd.fill_dec || cmd.fill_inc) fill_ok_ff[bkt_ff] <= 1'b1;
   end

   // Iteration cursor.
   always_ff @(posedge clock) begin
      if (reset || cmd.cur_clear) begin
         cb_ff <= '0; cs_ff <= '0;
      end else if (cmd.cur_next) begin
         cb_ff <= cb_ff + 1'b1; cs_ff <= '0;
      end else if (cmd.cur_bump) cs_ff <= cs_ff + 1'b1;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.rsp_set) rv_ff <= 1'b1;
      else if (rsp_ready) rv_ff <= 1'b0;
      if (cmd.rsp_set) begin
         rs_ff <= cmd.status;
         rk_ff <= cmd.out_data ? rkey_ff : '0;
         ro_ff <= (cmd.out_data || cmd.out_val) ? rval_ff : '0;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_out_key = rk_ff;
   assign rsp_out_value = ro_ff;

   // Status to the controller. In S_SHIFT cur_in means idx below fill for delete,
   // and a pop always reads its head. In S_BKT it means cursor slot below fill.
   always_comb begin
      st.mode = mode_ff;
      st.key_match = (rkey_ff == key_ff);
      st.idx_end = (FW'(idx_ff + 1'b1) >= fill_ff) || (idx_ff == FW'(WAYS - 1));
      st.fill_zero = (fill_ff == '0);
      st.fill_full = (fill_ff >= FW'(WAYS));
      st.cur_in = (mode_ff == MODE_DEL) ? (idx_ff < fill_ff) :
                  (mode_ff == MODE_NEXT) ? (cs_ff < fill_ff) : 1'b1;
      st.bkt_last = cmd.use_cursor ? (cb_ff == CW'(BUCKETS - 1))
                                   : (bkt_ff == BW'(BUCKETS - 1));
      st.cur_end = (cb_ff >= CW'(BUCKETS));
      st.hit = hit_ff;
      st.rsp_busy = rv_ff && !rsp_ready;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |-> (fill_ff < FW'(WAYS)))
      else $error("add beyond bucket capacity");
   a_dec_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_dec |-> (fill_ff != '0))
      else $error("remove from empty bucket");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_ready) |=> rv_ff)
      else $error("result dropped while stalled");
`endif

endmodule

@@ src/bucketed_hash_key_value_table.sv @@
// Top level of the bucketed hash key-value table.
// Depends on bhkv_pkg, bhkv_if, bhkv_ctrl and bhkv_dp.
//
//  channel | dir | payload                          | accepted when
//  req     | in  | mode[2:0] key[63:0] value[63:0]  | valid && ready
//  rsp     | out | status[2:0] out_key out_value    | valid && ready
//
// One request at a time. Find/add/delete scan the slots of one bucket (at most WAYS
// slots); delete also moves the slots above the hit down one. Pop and iteration next
// walk buckets until one has an entry to return; the bucket walk sets the worst case.
// Reset is synchronous and clears fills (valid bits per bucket) and the cursor at once.
// A stalled result holds; the next request is taken once the result is gone or leaving.
module bucketed_hash_key_value_table
   import bhkv_pkg::*;
#(
   parameter int BUCKETS = 256,
   parameter int WAYS = 8
) (
   input logic clock,
   input logic reset,
   bhkv_if.sink   req,
   bhkv_if.source rsp
);

   cmd_type  cmd;
   stat_type st;

   bhkv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .st(st), .cmd(cmd)
   );

   bhkv_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
      .clock(clock), .reset(reset),
      .req_mode(req.data[130:128]), .req_key(req.data[127:64]),
      .req_value(req.data[63:0]),
      .cmd(cmd), .st(st),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_status(rsp.data[130:128]), .rsp_out_key(rsp.data[127:64]),
      .rsp_out_value(rsp.data[63:0])
   );

endmodule

@@ dv/bucketed_hash_key_value_table_tb.sv @@
// Self-checking testbench for the bucketed hash key-value table.
// Depends on bhkv_pkg, bhkv_if and bucketed_hash_key_value_table.
module bucketed_hash_key_value_table_tb;
   import bhkv_pkg::*;

   localparam int NBKT = 256;
   localparam int NWAY = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] key;
      logic [63:0] value;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] out_key;
      logic [63:0] out_value;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bhkv_if #(.W($bits(request_type)))  req_ch ();
   bhkv_if #(.W($bits(response_type))) rsp_ch ();

   bucketed_hash_key_value_table #(.BUCKETS(NBKT), .WAYS(NWAY)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #1 clock = ~clock;

   // Shadow copy of the table.
   logic [63:0] shadow_keys [NBKT*NWAY];
   logic [63:0] shadow_values [NBKT*NWAY];
   int unsigned shadow_fill [NBKT];
   int unsigned walk_bucket;
   int unsigned walk_slot;

   request_type  pending_requests [$];
   response_type expected_responses [$];
   int error_count = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   bit quiet_phase = 0;
   bit hold_sender = 0;
   int idle_cycles = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic int find_slot(input int unsigned b, input logic [63:0] k);
      for (int i = 0; i < shadow_fill[b]; i++)
         if (shadow_keys[b*NWAY+i] == k) return i;
      return -1;
   endfunction

   // Predicts the response of one request and updates the shadow table.
   function automatic response_type table_predict(input request_type r);
      response_type o;
      int unsigned b;
      int unsigned n;
      int p;
      o = '0;
      o.status = ST_OK;
      b = r.key[7:0];
      case (r.mode)
         MODE_FIND: begin
            p = find_slot(b, r.key);
            if (p < 0) o.status = ST_NOT_FOUND;
            else o.out_value = shadow_values[b*NWAY+p];
         end
         MODE_ADD: begin
            if (find_slot(b, r.key) >= 0) o.status = ST_EXISTS;
            else if (shadow_fill[b] >= NWAY) o.status = ST_FULL;
            else begin
               n = shadow_fill[b];
               shadow_keys[b*NWAY+n] = r.key;
               shadow_values[b*NWAY+n] = r.value;
               shadow_fill[b] = n + 1;
            end
         end
         MODE_DEL: begin
            p = find_slot(b, r.key);
            if (p < 0) o.status = ST_NOT_FOUND;
            else begin
               n = shadow_fill[b];
               for (int i = p; i + 1 < n; i++) begin
                  shadow_keys[b*NWAY+i] = shadow_keys[b*NWAY+i+1];
                  shadow_values[b*NWAY+i] = shadow_values[b*NWAY+i+1];
               end
               shadow_fill[b] = n - 1;
            end
         end
         MODE_POP: begin
            o.status = ST_EMPTY;
            for (int i = 0; i < NBKT; i++) begin
               n = shadow_fill[i];
               if (n != 0) begin
                  o.out_key = shadow_keys[i*NWAY+n-1];
                  o.out_value = shadow_values[i*NWAY+n-1];
                  shadow_fill[i] = n - 1;
                  o.status = ST_OK;
                  break;
               end
            end
         end
         MODE_START: begin
            walk_bucket = 0;
            walk_slot = 0;
         end
         MODE_NEXT: begin
            o.status = ST_DONE;
            while (walk_bucket < NBKT) begin
               n = shadow_fill[walk_bucket];
               if (walk_slot < n) begin
                  o.out_key = shadow_keys[walk_bucket*NWAY+n-1-walk_slot];
                  o.out_value = shadow_values[walk_bucket*NWAY+n-1-walk_slot];
                  walk_slot++;
                  o.status = ST_OK;
                  break;
               end
               walk_bucket++;
               walk_slot = 0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic request_type make_request(input logic [2:0] m, input logic [63:0] k,
                                                input logic [63:0] v);
      request_type r;
      r.mode = m;
      r.key = k;
      r.value = v;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Keys mostly land in a few buckets so that fills, duplicates and full buckets occur.
   function automatic logic [63:0] pick_key(input bit fresh);
      logic [63:0] k;
      k = rand64();
      if (!fresh && $urandom_range(0, 3) != 0) k[63:8] = 56'($urandom_range(0, 11));
      case ($urandom_range(0, 3))
         0: k[7:0] = 8'($urandom_range(0, 3));
         1: k[7:0] = 8'(8'hFF - $urandom_range(0, 2));
         2: k[7:0] = 8'($urandom_range(0, 255));
         default: k[7:0] = 8'($urandom_range(100, 104));
      endcase
      return k;
   endfunction

   // Driver: presents pending requests with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) expected_responses.push_back(table_predict(req_ch.data));
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_requests.size() != 0 && !hold_sender) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_requests.pop_front();
            if (!quiet_phase && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 18);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response and applies random back-pressure.
   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", 64'(got.status), 64'd0);
            end else begin
               want = expected_responses.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.out_key !== want.out_key)
                  report_mismatch("out_key", got.out_key, want.out_key);
               if (got.out_value !== want.out_value)
                  report_mismatch("out_value", got.out_value, want.out_value);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 9) == 0) rsp_gap = $urandom_range(1, 18);
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d responses outstanding",
                  expected_responses.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_ch.valid || expected_responses.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [63:0] k;
      int unsigned sel;
      for (int i = 0; i < NBKT; i++) shadow_fill[i] = 0;
      walk_bucket = 0;
      walk_slot = 0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extremes, full bucket, walk, odd modes.
      pending_requests.push_back(make_request(MODE_POP, 0, 0));
      pending_requests.push_back(make_request(MODE_NEXT, 0, 0));
      pending_requests.push_back(make_request(MODE_FIND, '1, 0));
      pending_requests.push_back(make_request(MODE_DEL, '1, 0));
      pending_requests.push_back(make_request(MODE_ADD, '1, '1));
      pending_requests.push_back(make_request(MODE_ADD, 0, 0));
      pending_requests.push_back(make_request(MODE_ADD, '1, 64'h5));
      for (int i = 1; i <= 8; i++)
         pending_requests.push_back(make_request(MODE_ADD, 64'(i) << 8, 64'(i) * 3));
      pending_requests.push_back(make_request(MODE_FIND, '1, 0));
      pending_requests.push_back(make_request(MODE_FIND, 64'h300, 0));
      pending_requests.push_back(make_request(MODE_START, 0, 0));
      repeat (4) pending_requests.push_back(make_request(MODE_NEXT, 0, 0));
      pending_requests.push_back(make_request(MODE_DEL, 64'h300, 0));
      pending_requests.push_back(make_request(3'd6, '1, '1));
      pending_requests.push_back(make_request(3'd7, 0, 0));
      pending_requests.push_back(make_request(MODE_POP, 0, 0));

      // Random part: adds, lookups, deletes, pops and walks mixed.
      for (int n = 0; n < 1450; n++) begin
         sel = $urandom_range(0, 99);
         if (n == 700) begin
            wait_drained();
            hold_sender = 1;
            @(posedge clock);
            hold_sender = 0;
         end
         if (n == 1300) quiet_phase = 1;
         k = pick_key($urandom_range(0, 4) == 0);
         if (sel < 30) pending_requests.push_back(make_request(MODE_ADD, k, rand64()));
         else if (sel < 48) pending_requests.push_back(make_request(MODE_FIND, k, rand64()));
         else if (sel < 62) pending_requests.push_back(make_request(MODE_DEL, k, rand64()));
         else if (sel < 70) pending_requests.push_back(make_request(MODE_POP, k, rand64()));
         else if (sel < 74) pending_requests.push_back(make_request(MODE_START, k, rand64()));
         else if (sel < 98) pending_requests.push_back(make_request(MODE_NEXT, k, rand64()));
         else pending_requests.push_back(make_request(3'($urandom_range(6, 7)), k, rand64()));
         while (pending_requests.size() > 4) @(posedge clock);
      end

      wait_drained();
      repeat (2000) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ sim.f @@
src/bhkv_pkg.sv
src/bhkv_if.sv
src/bhkv_ctrl.sv
src/bhkv_dp.sv
src/bucketed_hash_key_value_table.sv
dv/bucketed_hash_key_value_table_tb.sv
